// File: src/crr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types and constants for the cascaded range remap pipeline.
// ----------------------------------------------------------------------------
package crr_pkg;

  // Fixed widths of the stream payload fields.
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned STAGE_IDX_W = 3;
  localparam int unsigned SLOT_IDX_W  = 6;
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 32;

  // Request kind carried in tuser.
  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  // Request fields that travel down the pipeline next to the working value.
  typedef struct packed {
    func_e                  func;
    logic [STAGE_IDX_W-1:0] stage_index;
    logic [SLOT_IDX_W-1:0]  slot_index;
    logic [FIELD_W-1:0]     source_base;
    logic [FIELD_W-1:0]     dest_base;
    logic [FIELD_W-1:0]     window_length;
    logic                   entry_enable;
  } crr_req_t;

endpackage

// File: src/crr_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_stage
// One remap table and its three pipeline steps: window match, priority
// select of the winning entry's offset, and the final add.
// ----------------------------------------------------------------------------
module crr_stage #(
  parameter int unsigned STAGE_ID          = 0,
  parameter int unsigned ENTRIES_PER_STAGE = 64,
  parameter int unsigned VALUE_BITS        = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  crr_pkg::crr_req_t     req_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  valid_o,
  output crr_pkg::crr_req_t     req_o,
  output logic [VALUE_BITS-1:0] value_o
);
  import crr_pkg::*;

  // Table entries. The destination is kept as dest minus source, so that a
  // hit only needs one add at the end.
  logic [VALUE_BITS-1:0]        src_q   [ENTRIES_PER_STAGE];
  logic [VALUE_BITS-1:0]        len_q   [ENTRIES_PER_STAGE];
  logic [VALUE_BITS-1:0]        delta_q [ENTRIES_PER_STAGE];
  logic [ENTRIES_PER_STAGE-1:0] ent_valid_q;

  logic                         wr_hit;
  logic [VALUE_BITS-1:0]        wr_src;
  logic [VALUE_BITS-1:0]        wr_len;
  logic [VALUE_BITS-1:0]        wr_delta;

  logic [ENTRIES_PER_STAGE-1:0] match_d;
  logic [ENTRIES_PER_STAGE-1:0] onehot_d;
  logic [VALUE_BITS-1:0]        delta_d;
  logic [VALUE_BITS-1:0]        value3_d;

  logic                         valid1_q, valid2_q, valid3_q;
  crr_req_t                     req1_q, req2_q, req3_q;
  logic [VALUE_BITS-1:0]        value1_q, value2_q, value3_q;
  logic [ENTRIES_PER_STAGE-1:0] match1_q;
  logic [VALUE_BITS-1:0]        delta2_q;

  // A write request updates this table as it leaves the stage input. Any
  // lookup ahead of it has already finished reading the table by then.
  assign wr_hit   = valid_i && adv_i && (req_i.func == FUNC_WRITE) &&
                    (32'(req_i.stage_index) == STAGE_ID);
  assign wr_src   = VALUE_BITS'(req_i.source_base);
  assign wr_len   = VALUE_BITS'(req_i.window_length);
  assign wr_delta = VALUE_BITS'(req_i.dest_base) - wr_src;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else begin
      for (int unsigned k = 0; k < ENTRIES_PER_STAGE; k++) begin
        if (wr_hit && (32'(req_i.slot_index) == k)) begin
          ent_valid_q[k] <= req_i.entry_enable;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned k = 0; k < ENTRIES_PER_STAGE; k++) begin
      if (wr_hit && (32'(req_i.slot_index) == k)) begin
        src_q[k]   <= wr_src;
        len_q[k]   <= wr_len;
        delta_q[k] <= wr_delta;
      end
    end
  end

  // Step one: every entry checks its own half-open window, with wrap.
  always_comb begin
    logic [VALUE_BITS-1:0] off;
    match_d = '0;
    for (int unsigned k = 0; k < ENTRIES_PER_STAGE; k++) begin
      off        = value_i - src_q[k];
      match_d[k] = ent_valid_q[k] && (off < len_q[k]);
    end
  end

  // Step two: the lowest matching entry wins; no match selects a zero delta.
  assign onehot_d = match1_q & ((~match1_q) + ENTRIES_PER_STAGE'(1));

  always_comb begin
    delta_d = '0;
    for (int unsigned k = 0; k < ENTRIES_PER_STAGE; k++) begin
      delta_d = delta_d | ({VALUE_BITS{onehot_d[k]}} & delta_q[k]);
    end
  end

  // Step three: apply the offset.
  assign value3_d = value2_q + delta2_q;

  // Valid bits of the three steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (adv_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  // Payload of the three steps.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      req1_q   <= req_i;
      value1_q <= value_i;
      match1_q <= match_d;
      req2_q   <= req1_q;
      value2_q <= value1_q;
      delta2_q <= delta_d;
      req3_q   <= req2_q;
      value3_q <= value3_d;
    end
  end

  assign valid_o = valid3_q;
  assign req_o   = req3_q;
  assign value_o = value3_q;

endmodule

// File: src/cascaded_range_remap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_range_remap
// A lookup request, once accepted, passes one input register, then three
// registered steps per table, before it shows on m_axis.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits on m_axis. Write requests give no result.
// Reset: asynchronous, active low; clears all table valid bits and pipeline
// valid bits. No clearing pass is needed, requests are taken at once.
// ----------------------------------------------------------------------------
module cascaded_range_remap #(
  parameter int unsigned STAGE_COUNT       = 7,
  parameter int unsigned ENTRIES_PER_STAGE = 64,
  parameter int unsigned VALUE_BITS        = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // stage_index[2:0], slot_index[8:3], source_base[40:9], dest_base[72:41],
  // window_length[104:73], entry_enable[105], query_value[137:106], zero pad
  input  logic [crr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // func[0]
  input  logic [crr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // mapped_value[31:0]
  output logic [crr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import crr_pkg::*;

  logic                  adv;
  crr_req_t              in_req_d;

  logic                  chain_valid [STAGE_COUNT+1];
  crr_req_t              chain_req   [STAGE_COUNT+1];
  logic [VALUE_BITS-1:0] chain_value [STAGE_COUNT+1];

  logic                  in_valid_q;
  crr_req_t              in_req_q;
  logic [VALUE_BITS-1:0] in_value_q;

  // The pipeline moves unless a finished result is waiting.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Unpack the request.
  always_comb begin
    in_req_d.func          = func_e'(s_axis_tuser[0]);
    in_req_d.stage_index   = s_axis_tdata[2:0];
    in_req_d.slot_index    = s_axis_tdata[8:3];
    in_req_d.source_base   = s_axis_tdata[40:9];
    in_req_d.dest_base     = s_axis_tdata[72:41];
    in_req_d.window_length = s_axis_tdata[104:73];
    in_req_d.entry_enable  = s_axis_tdata[105];
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_req_q   <= in_req_d;
      in_value_q <= VALUE_BITS'(s_axis_tdata[137:106]);
    end
  end

  assign chain_valid[0] = in_valid_q;
  assign chain_req[0]   = in_req_q;
  assign chain_value[0] = in_value_q;

  // One table per stage, in order.
  for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
    crr_stage #(
      .STAGE_ID          (s),
      .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE),
      .VALUE_BITS        (VALUE_BITS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (chain_valid[s]),
      .req_i   (chain_req[s]),
      .value_i (chain_value[s]),
      .valid_o (chain_valid[s+1]),
      .req_o   (chain_req[s+1]),
      .value_o (chain_value[s+1])
    );
  end

  // The last stage's register is the output register; writes are dropped.
  assign m_axis_tvalid = chain_valid[STAGE_COUNT] &&
                         (chain_req[STAGE_COUNT].func == FUNC_LOOKUP);
  assign m_axis_tdata  = OUT_TDATA_W'(chain_value[STAGE_COUNT]);

endmodule

// File: src/crr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_checker
// Port-level checks of the remap pipeline's stall and reset behavior.
// ----------------------------------------------------------------------------
module crr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [crr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import crr_pkg::*;

  // A stalled result stays and holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or was dropped");

  // New requests are taken exactly when the pipeline can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  // The pipeline is empty right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

  // A request offered while the output stalls is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while the output stalls");

endmodule

bind cascaded_range_remap crr_checker u_crr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
